// ----- design/ticket_scheduler_with_transfer_macros.svh -----
// Assertion macros used by the checker file of the ticket scheduler.
// Depends on nothing; included by the checker module.
`ifndef TICKET_SCHEDULER_WITH_TRANSFER_MACROS_SVH
`define TICKET_SCHEDULER_WITH_TRANSFER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

// Next-cycle implication that is checked during reset as well.
`define ASSERT_NEXT_RAW(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- design/tsw_pkg.sv -----
// Shared types and constants of the ticket scheduler with ticket transfer.
// No dependencies; used by the top level and the checker.
package tsw_pkg;

    // Sequencer states.
    typedef enum logic [4:0] {
        S_IDLE,
        S_ARR_MUL,
        S_ARR_WR,
        S_TICK,
        S_RUN_CHK,
        S_LEND_RD,
        S_LEND_WR,
        S_BOOST,
        S_DIV,
        S_SCAN,
        S_PICK,
        S_LOCK_CHK,
        S_OWN_CHK,
        S_PARK,
        S_RUN,
        S_FIN,
        S_PUSH_T,
        S_PUSH_S
    } t_state;

    // Status of a table slot.
    typedef enum logic [1:0] {
        ST_READY   = 2'd0,
        ST_RUNNING = 2'd1,
        ST_PARKED  = 2'd2
    } t_status;

    localparam logic        FUNC_ARRIVAL  = 1'b0;
    localparam logic        FUNC_TICK     = 1'b1;
    localparam logic        KIND_SCHED    = 1'b0;
    localparam logic        KIND_TERM     = 1'b1;
    localparam logic [23:0] TICKET_MAX    = 24'hFF_FFFF;
    localparam logic [7:0]  QUANTUM_RESET = 8'd4;
    localparam logic [7:0]  SLICE_MAX     = 8'hFF;

endpackage

// ----- design/ticket_scheduler_with_transfer.sv -----
// Top level of the ticket scheduler with ticket transfer.
// Depends on tsw_pkg and tsw_ram.
//
// Usage:
//   Input stream (i_s_*): tuser selects arrival (0) or tick (1); tdata carries
//   the arriving process. One request is taken at a time: o_s_tready is high
//   only while the sequencer is idle.
//   Output stream (o_m_*): events only on ticks, of kind scheduled (tuser 0)
//   or terminated (tuser 1); tlast marks the last event of a tick. A tick gives
//   zero, one or two events, a termination always first.
//   Configuration (i_cfg_*): one 8-bit quantum register, always ready.
// Sequence:
//   An arrival applies any pending boost and finds a free slot, then writes it.
//   A tick checks the running process, then makes one pass over the slot table
//   per pick through the slot RAM read port, with a division when a boost is
//   recorded, a restore when a lender gets its tickets back and a ticket transfer.
// Reset: synchronous active low; empties the table, frees all locks, clears
//   pending boosts and counters, and sets the quantum to 4.
// Stall: results wait in a two-entry output queue; when it is full the
//   sequencer holds until the receiver takes a result.
module ticket_scheduler_with_transfer #(
    parameter int MAX_PROCS     = 16,
    parameter int MAX_RESOURCES = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream. tdata: proc_id[3:0], run_time[19:4], ticket_count[35:20],
    // has_resource[36], resource_id[40:37], zero fill above.
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [47:0] i_s_tdata,
    // tuser: func[0].
    input  logic        i_s_tuser,
    // Output stream. tdata: event_proc[3:0], event_time[19:4], zero fill above.
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,
    // tuser: event_kind[0]. tlast: last_event.
    output logic        o_m_tuser,
    output logic        o_m_tlast,
    // Quantum register write.
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_data
);

    localparam int PW = $clog2(MAX_PROCS);
    localparam int RW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;

    typedef struct packed {
        logic [3:0]       proc;
        logic [15:0]      remaining;
        logic [23:0]      tickets;
        logic [23:0]      lent;
        logic             lender_v;
        logic [PW-1:0]    lender;
        logic             res_v;
        logic [RW-1:0]    res;
        tsw_pkg::t_status status;
        logic [15:0]      order;
    } t_slot;

    // Control registers.
    tsw_pkg::t_state r_state, n_state;
    logic [7:0]  r_quantum;
    logic [MAX_PROCS-1:0] r_used, n_used;
    logic [MAX_RESOURCES-1:0] r_lock_v, n_lock_v;
    logic [7:0]  r_boost [16];
    logic [7:0]  n_boost [16];
    logic        r_run_v, n_run_v;
    logic [PW-1:0] r_run, n_run;
    logic [7:0]  r_slice, n_slice;
    logic [15:0] r_tick, n_tick;
    logic [15:0] r_order, n_order;
    logic        r_term_pend, n_term_pend;
    logic        r_sched_v, n_sched_v;
    logic [PW:0] r_idx, n_idx;
    logic        r_chk_v, n_chk_v;
    logic        r_best_v, n_best_v;
    logic [3:0]  r_div_cnt, n_div_cnt;

    // Payload registers.
    logic [3:0]  r_in_proc;
    logic [15:0] r_in_run;
    logic [15:0] r_in_tickets;
    logic        r_in_res_v;
    logic [RW-1:0] r_in_res;
    logic [23:0] r_prod, n_prod;
    logic [PW-1:0] r_free, n_free;
    t_slot       r_cur, n_cur;
    logic [3:0]  r_term_proc, n_term_proc;
    logic [3:0]  r_sched_proc, n_sched_proc;
    logic [PW-1:0] r_lidx, n_lidx;
    logic [23:0] r_lent, n_lent;
    logic [PW-1:0] r_chk_idx, n_chk_idx;
    logic [PW-1:0] r_best_idx, n_best_idx;
    t_slot       r_best, n_best;
    logic [PW-1:0] r_owner, n_owner;
    logic [7:0]  r_div_rem, n_div_rem;
    logic [7:0]  r_div_num, n_div_num;
    logic [7:0]  r_div_d, n_div_d;
    logic [3:0]  r_boost_id, n_boost_id;

    // Output queue.
    logic        r_q_kind [2];
    logic [3:0]  r_q_proc [2];
    logic [15:0] r_q_time [2];
    logic        r_q_last [2];
    logic        r_q_wp, r_q_rp;
    logic [1:0]  r_q_cnt;
    logic        push_v, push_kind, push_last;
    logic [3:0]  push_proc;
    logic        pop_v;

    // Memory ports.
    logic          slot_we;
    logic [PW-1:0] slot_waddr, slot_raddr;
    t_slot         slot_wdata, slot_rdata;
    logic          lock_we;
    logic [RW-1:0] lock_waddr, lock_raddr;
    logic [PW-1:0] lock_wdata, lock_rdata;

    // Helper values.
    logic        s_accept;
    logic        free_found;
    logic [PW-1:0] free_idx;
    logic [7:0]  boost_sel;
    logic [23:0] mul_out;
    logic [15:0] age_new, age_best;
    logic        better;
    logic [24:0] ticket_sum;
    logic [8:0]  div_trial;
    logic        div_ge;
    t_slot       rec;

    tsw_ram #(.WIDTH($bits(t_slot)), .DEPTH(MAX_PROCS)) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (slot_we),
        .i_waddr (slot_waddr),
        .i_wdata (slot_wdata),
        .i_raddr (slot_raddr),
        .o_rdata (slot_rdata)
    );

    tsw_ram #(.WIDTH(PW), .DEPTH(MAX_RESOURCES)) u_lock_ram (
        .i_clk   (i_clk),
        .i_we    (lock_we),
        .i_waddr (lock_waddr),
        .i_wdata (lock_wdata),
        .i_raddr (lock_raddr),
        .o_rdata (lock_rdata)
    );

    assign o_s_tready  = (r_state == tsw_pkg::S_IDLE);
    assign s_accept    = i_s_tvalid && o_s_tready;
    assign o_cfg_ready = 1'b1;

    assign o_m_tvalid = (r_q_cnt != 2'd0);
    assign o_m_tdata  = {4'd0, r_q_time[r_q_rp], r_q_proc[r_q_rp]};
    assign o_m_tuser  = r_q_kind[r_q_rp];
    assign o_m_tlast  = r_q_last[r_q_rp];
    assign pop_v      = o_m_tvalid && i_m_tready;

    // First free slot in the table.
    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = MAX_PROCS - 1; i >= 0; i--) begin
            if (!r_used[i]) begin
                free_found = 1'b1;
                free_idx   = PW'(i);
            end
        end
    end

    assign boost_sel  = r_boost[r_boost_id];
    assign mul_out    = 24'(r_in_tickets) * 24'(boost_sel);
    assign rec        = slot_rdata;
    assign age_new    = r_order - rec.order;
    assign age_best   = r_order - r_best.order;
    assign better     = !r_best_v || (rec.tickets > r_best.tickets) ||
                        ((rec.tickets == r_best.tickets) && (age_new > age_best));
    assign ticket_sum = {1'b0, rec.tickets} + {1'b0, r_best.tickets};
    assign div_trial  = {r_div_rem, r_div_num[7]};
    assign div_ge     = (div_trial >= {1'b0, r_div_d});

    // Sequencer: next state, memory accesses and result pushes.
    always_comb begin
        n_state      = r_state;
        n_used       = r_used;
        n_lock_v     = r_lock_v;
        n_boost      = r_boost;
        n_run_v      = r_run_v;
        n_run        = r_run;
        n_slice      = r_slice;
        n_tick       = r_tick;
        n_order      = r_order;
        n_term_pend  = r_term_pend;
        n_sched_v    = r_sched_v;
        n_idx        = r_idx;
        n_chk_v      = r_chk_v;
        n_best_v     = r_best_v;
        n_div_cnt    = r_div_cnt;
        n_prod       = r_prod;
        n_free       = r_free;
        n_cur        = r_cur;
        n_term_proc  = r_term_proc;
        n_sched_proc = r_sched_proc;
        n_lidx       = r_lidx;
        n_lent       = r_lent;
        n_chk_idx    = r_chk_idx;
        n_best_idx   = r_best_idx;
        n_best       = r_best;
        n_owner      = r_owner;
        n_div_rem    = r_div_rem;
        n_div_num    = r_div_num;
        n_div_d      = r_div_d;
        n_boost_id   = r_boost_id;
        slot_we      = 1'b0;
        slot_waddr   = r_run;
        slot_wdata   = r_cur;
        slot_raddr   = r_run;
        lock_we      = 1'b0;
        lock_waddr   = r_best.res;
        lock_wdata   = r_best_idx;
        lock_raddr   = r_best.res;
        push_v       = 1'b0;
        push_kind    = tsw_pkg::KIND_SCHED;
        push_proc    = r_sched_proc;
        push_last    = 1'b1;

        unique case (r_state)
            tsw_pkg::S_IDLE: begin
                if (s_accept) begin
                    n_boost_id = i_s_tdata[3:0];
                    n_state    = (i_s_tuser == tsw_pkg::FUNC_ARRIVAL) ?
                                 tsw_pkg::S_ARR_MUL : tsw_pkg::S_TICK;
                end
            end

            // Apply a pending boost and find a free slot.
            tsw_pkg::S_ARR_MUL: begin
                n_prod  = (boost_sel != 8'd0) ? mul_out : 24'(r_in_tickets);
                n_free  = free_idx;
                n_state = free_found ? tsw_pkg::S_ARR_WR : tsw_pkg::S_IDLE;
            end

            tsw_pkg::S_ARR_WR: begin
                slot_we              = 1'b1;
                slot_waddr           = r_free;
                slot_wdata.proc      = r_in_proc;
                slot_wdata.remaining = r_in_run;
                slot_wdata.tickets   = r_prod;
                slot_wdata.lent      = 24'd0;
                slot_wdata.lender_v  = 1'b0;
                slot_wdata.lender    = '0;
                slot_wdata.res_v     = r_in_res_v;
                slot_wdata.res       = r_in_res;
                slot_wdata.status    = tsw_pkg::ST_READY;
                slot_wdata.order     = r_order;
                n_used[r_free]       = 1'b1;
                n_boost[r_in_proc]   = 8'd0;
                n_order              = r_order + 16'd1;
                n_state              = tsw_pkg::S_IDLE;
            end

            tsw_pkg::S_TICK: begin
                n_term_pend = 1'b0;
                n_sched_v   = 1'b0;
                slot_raddr  = r_run;
                n_state     = r_run_v ? tsw_pkg::S_RUN_CHK : tsw_pkg::S_SCAN;
            end

            // Running process: terminate, preempt or keep running.
            tsw_pkg::S_RUN_CHK: begin
                n_cur = rec;
                if (rec.remaining == 16'd0) begin
                    n_term_pend  = 1'b1;
                    n_term_proc  = rec.proc;
                    n_used[r_run] = 1'b0;
                    n_run_v      = 1'b0;
                    n_boost_id   = rec.proc;
                    n_lidx       = rec.lender;
                    n_lent       = rec.lent;
                    n_state      = tsw_pkg::S_BOOST;
                    if (rec.res_v) begin
                        n_lock_v[rec.res] = 1'b0;
                        if (rec.lender_v && r_used[rec.lender]) begin
                            n_state = tsw_pkg::S_LEND_RD;
                        end
                    end
                end else if (r_slice == r_quantum) begin
                    slot_we           = 1'b1;
                    slot_waddr        = r_run;
                    slot_wdata        = rec;
                    slot_wdata.status = tsw_pkg::ST_READY;
                    slot_wdata.order  = r_order;
                    n_order           = r_order + 16'd1;
                    n_run_v           = 1'b0;
                    n_state           = tsw_pkg::S_SCAN;
                end else begin
                    n_state = tsw_pkg::S_FIN;
                end
            end

            tsw_pkg::S_LEND_RD: begin
                slot_raddr = r_lidx;
                n_state    = tsw_pkg::S_LEND_WR;
            end

            // The lender gets its tickets back and rejoins the queue.
            tsw_pkg::S_LEND_WR: begin
                slot_we            = 1'b1;
                slot_waddr         = r_lidx;
                slot_wdata         = rec;
                slot_wdata.tickets = r_lent;
                slot_wdata.status  = tsw_pkg::ST_READY;
                slot_wdata.order   = r_order;
                n_order            = r_order + 16'd1;
                n_state            = tsw_pkg::S_BOOST;
            end

            // Early finish records quantum / slice as a boost.
            tsw_pkg::S_BOOST: begin
                if ((r_slice < r_quantum) && (r_slice != 8'd0) && (boost_sel == 8'd0)) begin
                    n_div_rem = 8'd0;
                    n_div_num = r_quantum;
                    n_div_d   = r_slice;
                    n_div_cnt = 4'd0;
                    n_state   = tsw_pkg::S_DIV;
                end else begin
                    n_state = tsw_pkg::S_SCAN;
                end
            end

            // One restoring-division bit per cycle.
            tsw_pkg::S_DIV: begin
                n_div_rem = div_ge ? 8'(div_trial - {1'b0, r_div_d}) : div_trial[7:0];
                n_div_num = {r_div_num[6:0], div_ge};
                n_div_cnt = r_div_cnt + 4'd1;
                if (r_div_cnt == 4'd7) begin
                    n_boost[r_boost_id] = {r_div_num[6:0], div_ge};
                    n_state             = tsw_pkg::S_SCAN;
                end
            end

            // Pipelined pass over the slot table for the best ready process.
            tsw_pkg::S_SCAN: begin
                slot_raddr = r_idx[PW-1:0];
                if (r_idx < (PW + 1)'(MAX_PROCS)) begin
                    n_chk_v   = 1'b1;
                    n_chk_idx = r_idx[PW-1:0];
                    n_idx     = r_idx + (PW + 1)'(1);
                end else begin
                    n_chk_v = 1'b0;
                end
                if (r_chk_v) begin
                    if (r_used[r_chk_idx] && (rec.status == tsw_pkg::ST_READY) && better) begin
                        n_best_v   = 1'b1;
                        n_best     = rec;
                        n_best_idx = r_chk_idx;
                    end
                    if (r_chk_idx == PW'(MAX_PROCS - 1)) begin
                        n_state = tsw_pkg::S_PICK;
                    end
                end
            end

            tsw_pkg::S_PICK: begin
                lock_raddr = r_best.res;
                if (!r_best_v) begin
                    n_state = tsw_pkg::S_FIN;
                end else if (r_best.res_v) begin
                    n_state = tsw_pkg::S_LOCK_CHK;
                end else begin
                    n_state = tsw_pkg::S_RUN;
                end
            end

            // Free lock is taken; a held lock needs the owner's record.
            tsw_pkg::S_LOCK_CHK: begin
                if (r_lock_v[r_best.res]) begin
                    n_owner    = lock_rdata;
                    slot_raddr = lock_rdata;
                    n_state    = tsw_pkg::S_OWN_CHK;
                end else begin
                    lock_we              = 1'b1;
                    n_lock_v[r_best.res] = 1'b1;
                    n_state              = tsw_pkg::S_RUN;
                end
            end

            // Transfer tickets to an owner with another id.
            tsw_pkg::S_OWN_CHK: begin
                if (rec.proc != r_best.proc) begin
                    slot_we             = 1'b1;
                    slot_waddr          = r_owner;
                    slot_wdata          = rec;
                    slot_wdata.tickets  = ticket_sum[24] ? tsw_pkg::TICKET_MAX :
                                          ticket_sum[23:0];
                    slot_wdata.lent     = r_best.tickets;
                    slot_wdata.lender_v = 1'b1;
                    slot_wdata.lender   = r_best_idx;
                    n_state             = tsw_pkg::S_PARK;
                end else begin
                    n_state = tsw_pkg::S_RUN;
                end
            end

            tsw_pkg::S_PARK: begin
                slot_we            = 1'b1;
                slot_waddr         = r_best_idx;
                slot_wdata         = r_best;
                slot_wdata.tickets = 24'd0;
                slot_wdata.status  = tsw_pkg::ST_PARKED;
                n_state            = tsw_pkg::S_SCAN;
            end

            tsw_pkg::S_RUN: begin
                n_run_v      = 1'b1;
                n_run        = r_best_idx;
                n_slice      = 8'd0;
                n_cur        = r_best;
                n_cur.status = tsw_pkg::ST_RUNNING;
                n_sched_v    = 1'b1;
                n_sched_proc = r_best.proc;
                n_state      = tsw_pkg::S_FIN;
            end

            // Charge one tick to the running process.
            tsw_pkg::S_FIN: begin
                if (r_run_v) begin
                    slot_we    = 1'b1;
                    slot_waddr = r_run;
                    slot_wdata = r_cur;
                    if (r_cur.remaining != 16'd0) begin
                        slot_wdata.remaining = r_cur.remaining - 16'd1;
                    end
                    if (r_slice != tsw_pkg::SLICE_MAX) begin
                        n_slice = r_slice + 8'd1;
                    end
                end
                n_state = tsw_pkg::S_PUSH_T;
            end

            tsw_pkg::S_PUSH_T: begin
                if (!r_term_pend) begin
                    n_state = tsw_pkg::S_PUSH_S;
                end else if ((r_q_cnt != 2'd2) || pop_v) begin
                    push_v    = 1'b1;
                    push_kind = tsw_pkg::KIND_TERM;
                    push_proc = r_term_proc;
                    push_last = !r_sched_v;
                    n_state   = tsw_pkg::S_PUSH_S;
                end
            end

            tsw_pkg::S_PUSH_S: begin
                if (!r_sched_v) begin
                    n_tick  = r_tick + 16'd1;
                    n_state = tsw_pkg::S_IDLE;
                end else if ((r_q_cnt != 2'd2) || pop_v) begin
                    push_v  = 1'b1;
                    n_tick  = r_tick + 16'd1;
                    n_state = tsw_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = tsw_pkg::S_IDLE;
            end
        endcase

        // A fresh table pass starts with an empty choice.
        if ((n_state == tsw_pkg::S_SCAN) && (r_state != tsw_pkg::S_SCAN)) begin
            n_idx    = '0;
            n_chk_v  = 1'b0;
            n_best_v = 1'b0;
        end
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= tsw_pkg::S_IDLE;
            r_quantum   <= tsw_pkg::QUANTUM_RESET;
            r_used      <= '0;
            r_lock_v    <= '0;
            for (int i = 0; i < 16; i++) begin
                r_boost[i] <= 8'd0;
            end
            r_run_v     <= 1'b0;
            r_run       <= '0;
            r_slice     <= 8'd0;
            r_tick      <= 16'd0;
            r_order     <= 16'd0;
            r_term_pend <= 1'b0;
            r_sched_v   <= 1'b0;
            r_idx       <= '0;
            r_chk_v     <= 1'b0;
            r_best_v    <= 1'b0;
            r_div_cnt   <= 4'd0;
        end else begin
            r_state     <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_quantum <= i_cfg_data;
            end
            r_used      <= n_used;
            r_lock_v    <= n_lock_v;
            r_boost     <= n_boost;
            r_run_v     <= n_run_v;
            r_run       <= n_run;
            r_slice     <= n_slice;
            r_tick      <= n_tick;
            r_order     <= n_order;
            r_term_pend <= n_term_pend;
            r_sched_v   <= n_sched_v;
            r_idx       <= n_idx;
            r_chk_v     <= n_chk_v;
            r_best_v    <= n_best_v;
            r_div_cnt   <= n_div_cnt;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_in_proc    <= i_s_tdata[3:0];
            r_in_run     <= i_s_tdata[19:4];
            r_in_tickets <= i_s_tdata[35:20];
            r_in_res_v   <= i_s_tdata[36] &&
                            ({28'd0, i_s_tdata[40:37]} < 32'(MAX_RESOURCES));
            r_in_res     <= RW'(i_s_tdata[40:37]);
        end
        r_prod       <= n_prod;
        r_free       <= n_free;
        r_cur        <= n_cur;
        r_term_proc  <= n_term_proc;
        r_sched_proc <= n_sched_proc;
        r_lidx       <= n_lidx;
        r_lent       <= n_lent;
        r_chk_idx    <= n_chk_idx;
        r_best_idx   <= n_best_idx;
        r_best       <= n_best;
        r_owner      <= n_owner;
        r_div_rem    <= n_div_rem;
        r_div_num    <= n_div_num;
        r_div_d      <= n_div_d;
        r_boost_id   <= n_boost_id;
    end

    // Output queue pointers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_wp  <= 1'b0;
            r_q_rp  <= 1'b0;
            r_q_cnt <= 2'd0;
        end else begin
            if (push_v) begin
                r_q_wp <= !r_q_wp;
            end
            if (pop_v) begin
                r_q_rp <= !r_q_rp;
            end
            r_q_cnt <= r_q_cnt + 2'(push_v) - 2'(pop_v);
        end
    end

    // Output queue entries.
    always_ff @(posedge i_clk) begin
        if (push_v) begin
            r_q_kind[r_q_wp] <= push_kind;
            r_q_proc[r_q_wp] <= push_proc;
            r_q_time[r_q_wp] <= r_tick;
            r_q_last[r_q_wp] <= push_last;
        end
    end

endmodule

// ----- design/tsw_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies; holds the slot table and the lock owner table.
module tsw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ----- design/tsw_checker.sv -----
// Port-level checks for the ticket scheduler, bound to its top level.
// Depends on tsw_pkg and the assertion macro header.
`include "ticket_scheduler_with_transfer_macros.svh"

module tsw_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_m_tvalid,
    input logic        i_m_tready,
    input logic [23:0] o_m_tdata,
    input logic        o_m_tuser,
    input logic        o_m_tlast
);

    logic        r_pair;
    logic [15:0] r_pair_time;

    // A termination that is not last must be followed by a schedule.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pair <= 1'b0;
        end else if (o_m_tvalid && i_m_tready) begin
            r_pair      <= (o_m_tuser == tsw_pkg::KIND_TERM) && !o_m_tlast;
            r_pair_time <= o_m_tdata[19:4];
        end
    end

    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser) && $stable(o_m_tlast))
    `ASSERT_IMPL(a_pair, i_clk, i_rst_n, o_m_tvalid && r_pair, (o_m_tuser == tsw_pkg::KIND_SCHED) && o_m_tlast && (o_m_tdata[19:4] == r_pair_time))
    `ASSERT_NEXT_RAW(a_reset, i_clk, !i_rst_n, !o_m_tvalid)

endmodule

bind ticket_scheduler_with_transfer tsw_checker u_tsw_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tuser  (o_m_tuser),
    .o_m_tlast  (o_m_tlast)
);

// ----- dv/tb_ticket_scheduler_with_transfer.sv -----
// Self-checking testbench of the ticket scheduler with ticket transfer.
// Depends on tsw_pkg and the top level ticket_scheduler_with_transfer.
`timescale 1ns / 1ps

// Event predictor and checker: holds its own copy of the process table.
class tsw_scoreboard;
    typedef struct {
        logic        kind;
        logic [3:0]  proc;
        logic [15:0] stamp;
        logic        last;
    } t_sched_event;

    t_sched_event awaited_events[$];
    int           errors;

    logic [7:0]   quantum;
    bit           used[16];
    logic [3:0]   pid[16];
    logic [15:0]  remaining[16];
    logic [23:0]  tickets[16];
    logic [23:0]  lent[16];
    int           lender[16];
    int           need_res[16];
    tsw_pkg::t_status status[16];
    logic [15:0]  order[16];
    int           lock_owner[16];
    logic [7:0]   boost[16];
    int           running;
    logic [7:0]   slice;
    logic [15:0]  ticks;
    logic [15:0]  next_ord;

    function new();
        quantum = tsw_pkg::QUANTUM_RESET;
        for (int i = 0; i < 16; i++) begin
            used[i] = 0;
            lender[i] = -1;
            need_res[i] = -1;
            lock_owner[i] = -1;
            boost[i] = 8'd0;
        end
        running = -1;
        slice = 8'd0;
        ticks = 16'd0;
        next_ord = 16'd0;
        errors = 0;
    endfunction

    function void set_quantum(logic [7:0] value);
        quantum = value;
    endfunction

    function void enqueue(int s);
        status[s] = tsw_pkg::ST_READY;
        order[s] = next_ord;
        next_ord = next_ord + 16'd1;
    endfunction

    // Most tickets wins; the oldest in queue order on ties.
    function int pick_ready();
        int          best;
        logic [23:0] best_t;
        logic [15:0] best_age;
        logic [15:0] age;
        best = -1;
        best_t = 24'd0;
        best_age = 16'd0;
        for (int s = 0; s < 16; s++) begin
            if (used[s] && status[s] == tsw_pkg::ST_READY) begin
                age = next_ord - order[s];
                if (best < 0 || tickets[s] > best_t ||
                    (tickets[s] == best_t && age > best_age)) begin
                    best = s;
                    best_t = tickets[s];
                    best_age = age;
                end
            end
        end
        return best;
    endfunction

    // Termination: free the lock, give the lender back its tickets, note a boost.
    function void retire(int r);
        int l;
        if (need_res[r] >= 0) begin
            lock_owner[need_res[r]] = -1;
            l = lender[r];
            if (l >= 0 && used[l]) begin
                tickets[l] = lent[r];
                enqueue(l);
            end
        end
        if (slice < quantum && slice != 8'd0) begin
            if (boost[pid[r]] == 8'd0)
                boost[pid[r]] = quantum / slice;
        end
        lender[r] = -1;
        used[r] = 0;
    endfunction

    // Works out the events that one accepted request causes.
    function void note_request(logic func, logic [3:0] id, logic [15:0] run,
                               logic [15:0] tk, logic hr, logic [3:0] res);
        t_sched_event fresh[$];
        t_sched_event ev;
        int           s;
        int           c;
        int           o;
        logic [31:0]  prod;
        logic [24:0]  sum;
        if (func == tsw_pkg::FUNC_ARRIVAL) begin
            s = -1;
            for (int i = 0; i < 16; i++)
                if (s < 0 && !used[i]) s = i;
            if (s < 0) return;
            prod = {16'd0, tk};
            if (boost[id] != 8'd0) begin
                prod = prod * boost[id];
                if (prod > {8'd0, tsw_pkg::TICKET_MAX}) prod = {8'd0, tsw_pkg::TICKET_MAX};
                boost[id] = 8'd0;
            end
            used[s] = 1;
            pid[s] = id;
            remaining[s] = run;
            tickets[s] = prod[23:0];
            lent[s] = 24'd0;
            lender[s] = -1;
            need_res[s] = hr ? int'(res) : -1;
            enqueue(s);
            return;
        end
        // Running process first.
        if (running >= 0) begin
            if (remaining[running] == 16'd0) begin
                ev = '{tsw_pkg::KIND_TERM, pid[running], ticks, 1'b0};
                fresh.insert(fresh.size(), ev);
                retire(running);
                running = -1;
            end else if (slice == quantum) begin
                enqueue(running);
                running = -1;
            end
        end
        // Pick, parking any process that waits on a lock of another id.
        if (running < 0) begin
            forever begin
                c = pick_ready();
                if (c < 0) break;
                if (need_res[c] >= 0) begin
                    o = lock_owner[need_res[c]];
                    if (o >= 0 && pid[o] != pid[c]) begin
                        sum = {1'b0, tickets[o]} + {1'b0, tickets[c]};
                        tickets[o] = sum[24] ? tsw_pkg::TICKET_MAX : sum[23:0];
                        lent[o] = tickets[c];
                        lender[o] = c;
                        tickets[c] = 24'd0;
                        status[c] = tsw_pkg::ST_PARKED;
                        continue;
                    end
                    if (o < 0) lock_owner[need_res[c]] = c;
                end
                status[c] = tsw_pkg::ST_RUNNING;
                running = c;
                slice = 8'd0;
                ev = '{tsw_pkg::KIND_SCHED, pid[c], ticks, 1'b0};
                fresh.insert(fresh.size(), ev);
                break;
            end
        end
        if (running >= 0) begin
            if (remaining[running] != 16'd0) remaining[running] -= 16'd1;
            if (slice != tsw_pkg::SLICE_MAX) slice += 8'd1;
        end
        ticks += 16'd1;
        if (fresh.size() > 0) fresh[fresh.size() - 1].last = 1'b1;
        foreach (fresh[i]) awaited_events.insert(awaited_events.size(), fresh[i]);
    endfunction

    task report_mismatch(string msg);
        $display("ERROR at %0t: %s", $realtime, msg);
        errors++;
    endtask

    // Compares one accepted event with the oldest one awaited.
    task check_event(logic kind, logic [3:0] proc, logic [15:0] stamp, logic last);
        t_sched_event exp_ev;
        if (awaited_events.size() == 0) begin
            report_mismatch($sformatf("unexpected event kind %0d proc %0d", kind, proc));
            return;
        end
        exp_ev = awaited_events[0];
        awaited_events.delete(0);
        if (kind !== exp_ev.kind)
            report_mismatch($sformatf("kind %0d, want %0d", kind, exp_ev.kind));
        if (proc !== exp_ev.proc)
            report_mismatch($sformatf("proc %0d, want %0d", proc, exp_ev.proc));
        if (stamp !== exp_ev.stamp)
            report_mismatch($sformatf("time %0d, want %0d", stamp, exp_ev.stamp));
        if (last !== exp_ev.last)
            report_mismatch($sformatf("last %0d, want %0d", last, exp_ev.last));
    endtask
endclass

module tb_ticket_scheduler_with_transfer;
    localparam int STALL_LIMIT = 5000;
    localparam int HOLD_CYCLES = 400;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_s_tvalid;
    logic        o_s_tready;
    logic [47:0] i_s_tdata;
    logic        i_s_tuser;
    logic        o_m_tvalid;
    logic        i_m_tready;
    logic [23:0] o_m_tdata;
    logic        o_m_tuser;
    logic        o_m_tlast;
    logic        i_cfg_valid;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_data;

    tsw_scoreboard sb;
    int  tx_idle_pct;
    int  rx_stall_pct;
    bit  hold_req;
    int  hold_left;
    int  quiet_cycles;

    ticket_scheduler_with_transfer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .i_s_tuser   (i_s_tuser),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tuser   (o_m_tuser),
        .o_m_tlast   (o_m_tlast),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    // Clock.
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Event check at the rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready)
            sb.check_event(o_m_tuser, o_m_tdata[3:0], o_m_tdata[19:4], o_m_tlast);
    end

    // Receiver: random stalls, or a long hold-off when one is requested.
    always @(negedge i_clk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req = 0;
        end
        if (hold_left > 0) begin
            i_m_tready = 1'b0;
            hold_left--;
        end else begin
            i_m_tready = ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Watchdog over cycles in which no request, event or quantum write is accepted.
    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready) || !i_rst_n) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT) begin
                $display("ticket_scheduler_with_transfer: mismatch");
                $finish;
            end
        end
    end

    // Offers one request and returns at the falling edge after it is taken.
    task send_request(logic func, logic [3:0] id, logic [15:0] run,
                      logic [15:0] tk, logic hr, logic [3:0] res);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_s_tvalid = 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid = 1'b1;
        i_s_tuser = func;
        i_s_tdata = {7'd0, res, hr, tk, run, id};
        do @(posedge i_clk); while (!o_s_tready);
        sb.note_request(func, id, run, tk, hr, res);
        @(negedge i_clk);
    endtask

    task send_arrival(logic [3:0] id, logic [15:0] run, logic [15:0] tk,
                      logic hr, logic [3:0] res);
        send_request(tsw_pkg::FUNC_ARRIVAL, id, run, tk, hr, res);
    endtask

    // A tick carries random content in the unused fields.
    task send_tick();
        send_request(tsw_pkg::FUNC_TICK, 4'($urandom), 16'($urandom), 16'($urandom),
                     1'($urandom), 4'($urandom));
    endtask

    task send_random();
        logic [15:0] run;
        logic [15:0] tk;
        int          pick;
        if ($urandom_range(99) < 35) begin
            pick = $urandom_range(99);
            if (pick < 85) run = 16'($urandom_range(8));
            else if (pick < 99) run = 16'($urandom_range(64));
            else run = 16'($urandom);
            pick = $urandom_range(99);
            if (pick < 5) tk = 16'd0;
            else if (pick < 10) tk = 16'hFFFF;
            else if (pick < 50) tk = 16'($urandom_range(20));
            else tk = 16'($urandom);
            send_arrival(4'($urandom), run, tk, ($urandom_range(99) < 20),
                         4'($urandom));
        end else begin
            send_tick();
        end
    endtask

    task wait_drained();
        i_s_tvalid = 1'b0;
        while (sb.awaited_events.size() != 0) @(negedge i_clk);
    endtask

    // Quantum write, only with the block idle.
    task write_quantum(logic [7:0] value);
        wait_drained();
        repeat (100) @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_quantum(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata = '0;
        i_s_tuser = 1'b0;
        i_m_tready = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = 8'd0;
        tx_idle_pct = 0;
        rx_stall_pct = 0;
        hold_req = 0;
        hold_left = 0;
        quiet_cycles = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: extremes, locks, same id, zero run time, boost, full table.
        write_quantum(8'd3);
        send_arrival(4'd0, 16'd0, 16'd0, 1'b0, 4'd0);
        send_arrival(4'd15, 16'hFFFF, 16'd0, 1'b0, 4'd15);
        send_arrival(4'd1, 16'd3, 16'd100, 1'b1, 4'd2);
        send_arrival(4'd2, 16'd2, 16'd50, 1'b1, 4'd2);
        send_arrival(4'd1, 16'd1, 16'd40, 1'b1, 4'd2);
        send_arrival(4'd3, 16'd0, 16'hFFFF, 1'b1, 4'd15);
        repeat (12) send_tick();
        send_arrival(4'd3, 16'd2, 16'hFFFF, 1'b0, 4'd9);
        for (int i = 4; i < 16; i++)
            send_arrival(4'(i), 16'd1, 16'd10, 1'b0, 4'd0);
        send_arrival(4'd9, 16'd1, 16'd10, 1'b1, 4'd7);
        repeat (6) send_tick();

        // Random phases with different idling and quantum settings.
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    tx_idle_pct = 0; rx_stall_pct = 0; write_quantum(8'd1);
                end
                1: begin
                    tx_idle_pct = 73; rx_stall_pct = 0; write_quantum(8'd255);
                end
                2: begin
                    tx_idle_pct = 0; rx_stall_pct = 73; write_quantum(8'd0);
                end
                default: begin
                    tx_idle_pct = 15; rx_stall_pct = 15;
                    write_quantum(8'($urandom_range(2, 16)));
                end
            endcase
            for (int i = 0; i < 500; i++) begin
                if (ph == 0 && i == 250) hold_req = 1;
                if (ph == 1 && i == 250) wait_drained();
                send_random();
            end
        end

        wait_drained();
        repeat (200) @(negedge i_clk);
        if (sb.awaited_events.size() != 0)
            sb.report_mismatch("events still awaited at the end");
        if (sb.errors == 0) begin
            $display("ticket_scheduler_with_transfer: match");
        end else begin
            $display("ticket_scheduler_with_transfer: mismatch");
        end
        $finish;
    end
endmodule
